### design/unsigned_float_multiplier_assert.svh
// Assertion macros for the unsigned float multiplier
`ifndef UNSIGNED_FLOAT_MULTIPLIER_ASSERT_SVH
`define UNSIGNED_FLOAT_MULTIPLIER_ASSERT_SVH
`ifndef SYNTH
`define UFM_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define UFM_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define UFM_ASSERT_CLK(label, clk, rst, prop)
`define UFM_ASSERT_RST(label, clk, prop)
`endif
`endif

### design/ufm_pkg.sv
// Shared constants for the unsigned float multiplier
package ufm_pkg;
   localparam int ExpWidth = 8;
   localparam int MantWidth = 23;
   localparam int FieldWidth = 31;
   localparam int SigWidth = MantWidth + 1;
   localparam int ProdWidth = 2 * SigWidth;
   localparam int HalfWidth = (SigWidth + 1) / 2;
   localparam int Bias = (1 << (ExpWidth - 1)) - 1;
   localparam int Stages = 4;
endpackage

### design/unsigned_float_multiplier.sv
// Unsigned float multiplier, truncating, no sign.
// Throughput: one word per cycle; a four-stage pipeline with
// a global stall when the rsp word is held.
// Reset: synchronous active high, clears the stage valid bits only.
`include "unsigned_float_multiplier_assert.svh"
module unsigned_float_multiplier (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ufm_pkg::FieldWidth-1:0]    req_operand_a,
   input  logic [ufm_pkg::FieldWidth-1:0]    req_operand_b,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ufm_pkg::FieldWidth-1:0]    rsp_product
);
   logic [ufm_pkg::Stages-1:0] valid_ff, valid_in;
   logic advance;
   logic rsp_stall;

   assign advance = rsp_ready || !valid_ff[ufm_pkg::Stages-1];
   assign req_ready = advance;
   assign rsp_valid = valid_ff[ufm_pkg::Stages-1];
   assign valid_in = {valid_ff[ufm_pkg::Stages-2:0], req_valid};
   assign rsp_stall = rsp_valid && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   ufm_core u_core (
      .clock     (clock),
      .advance   (advance),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .product   (rsp_product)
   );

   `UFM_ASSERT_CLK(hold_on_stall, clock, reset, rsp_stall |=> (rsp_valid && $stable(rsp_product)))
   `UFM_ASSERT_CLK(ready_when_empty, clock, reset, (!rsp_valid) |-> req_ready)
   `UFM_ASSERT_RST(clear_after_reset, clock, reset |=> !rsp_valid)
endmodule

### design/ufm_core.sv
// Pipelined datapath of the unsigned float multiplier
module ufm_core (
   input  logic                              clock,
   input  logic                              advance,
   input  logic [ufm_pkg::FieldWidth-1:0]    operand_a,
   input  logic [ufm_pkg::FieldWidth-1:0]    operand_b,
   output logic [ufm_pkg::FieldWidth-1:0]    product
);
   localparam int MW = ufm_pkg::MantWidth;
   localparam int EW = ufm_pkg::ExpWidth;
   localparam int SW = ufm_pkg::SigWidth;
   localparam int HW = ufm_pkg::HalfWidth;
   localparam int PW = ufm_pkg::ProdWidth;
   localparam int XW = EW + 2;

   logic [SW-1:0] sa_ff, sb_ff;
   logic [XW-1:0] esum1_ff, esum2_ff, esum3_ff;
   logic          zero1_ff, zero2_ff, zero3_ff;
   logic [PW-1:0] lo_ff, mid_a_ff, mid_b_ff, hi_ff, prod_ff;
   logic [ufm_pkg::FieldWidth-1:0] product_ff, product_in;

   logic [MW-1:0] ma, mb;
   logic [EW-1:0] ea, eb;
   logic [2*HW-1:0] sa_ext, sb_ext;
   logic [HW-1:0] al, ah, bl, bh;
   logic geq2;
   logic [XW-1:0] efinal;
   logic [MW-1:0] mres;

   always_comb begin
      ma = operand_a[MW-1:0];
      mb = operand_b[MW-1:0];
      ea = operand_a[MW+EW-1:MW];
      eb = operand_b[MW+EW-1:MW];
      sa_ext = (2*HW)'(sa_ff);
      sb_ext = (2*HW)'(sb_ff);
      al = sa_ext[HW-1:0];
      ah = sa_ext[2*HW-1:HW];
      bl = sb_ext[HW-1:0];
      bh = sb_ext[2*HW-1:HW];
      geq2 = prod_ff[PW-1];
      efinal = esum3_ff + XW'(geq2);
      mres = geq2 ? prod_ff[PW-2 -: MW] : prod_ff[PW-3 -: MW];
      if (zero3_ff || efinal[XW-1]) begin
         product_in = '0;
      end else begin
         product_in = ufm_pkg::FieldWidth'({efinal[EW-1:0], mres});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sa_ff    <= {1'b1, ma};
         sb_ff    <= {1'b1, mb};
         esum1_ff <= XW'(ea) + XW'(eb) - XW'(ufm_pkg::Bias);
         zero1_ff <= (operand_a[MW+EW-1:0] == '0) || (operand_b[MW+EW-1:0] == '0);
         lo_ff    <= PW'(al * bl);
         mid_a_ff <= PW'(al * bh);
         mid_b_ff <= PW'(ah * bl);
         hi_ff    <= PW'(ah * bh);
         esum2_ff <= esum1_ff;
         zero2_ff <= zero1_ff;
         prod_ff  <= lo_ff + ((mid_a_ff + mid_b_ff) << HW) + (hi_ff << (2*HW));
         esum3_ff <= esum2_ff;
         zero3_ff <= zero2_ff;
         product_ff <= product_in;
      end
   end

   assign product = product_ff;
endmodule

### tb/unsigned_float_multiplier_tb.sv
// Testbench for the unsigned float multiplier: directed table plus random words
module unsigned_float_multiplier_tb;
   localparam int ExpWidth = ufm_pkg::ExpWidth;
   localparam int MantWidth = ufm_pkg::MantWidth;
   localparam int FieldWidth = ufm_pkg::FieldWidth;
   localparam int ProdWidth = ufm_pkg::ProdWidth;
   localparam int Bias = ufm_pkg::Bias;

   typedef logic [FieldWidth-1:0] word_type;
   typedef struct {
      word_type a;
      word_type b;
      logic     known;
      word_type want;
   } row_type;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   word_type req_operand_a;
   word_type req_operand_b;
   logic     rsp_valid;
   logic     rsp_ready;
   word_type rsp_product;

   word_type expected_products[$];
   int       error_count;

   unsigned_float_multiplier u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_product(rsp_product)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic word_type float_product(word_type a, word_type b);
      logic [MantWidth-1:0] ma, mb, mres;
      logic [ExpWidth-1:0]  ea, eb;
      logic [ProdWidth-1:0] sig;
      logic                 geq2;
      int                   esum;
      ma = a[MantWidth-1:0];
      mb = b[MantWidth-1:0];
      ea = a[MantWidth +: ExpWidth];
      eb = b[MantWidth +: ExpWidth];
      sig = {1'b1, ma} * {1'b1, mb};
      geq2 = sig[ProdWidth-1];
      mres = geq2 ? sig[MantWidth+1 +: MantWidth] : sig[MantWidth +: MantWidth];
      esum = int'(ea) + int'(eb) - Bias + int'(geq2);
      if ((ea == 0 && ma == 0) || (eb == 0 && mb == 0) || esum < 0)
         return '0;
      return {esum[ExpWidth-1:0], mres};
   endfunction

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int gap_length();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic word_type random_operand();
      word_type v;
      v = word_type'($urandom);
      case ($urandom_range(0, 5))
         0: v[MantWidth +: ExpWidth] = ExpWidth'(Bias + $urandom_range(0, 8) - 4);
         1: v[MantWidth +: ExpWidth] = ExpWidth'($urandom_range(0, 3));
         2: v[MantWidth +: ExpWidth] = ExpWidth'((1 << ExpWidth) - 1 - $urandom_range(0, 3));
         3: v[MantWidth-1:0] = $urandom_range(0, 1) ? '0 : '1;
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_word(input word_type a, input word_type b);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_products.push_back(float_product(a, b));
   endtask

   localparam word_type One = word_type'(Bias) << MantWidth;
   localparam word_type Two = word_type'(Bias + 1) << MantWidth;
   localparam word_type Max = '1;
   localparam word_type OneHalf = One | (word_type'(1) << (MantWidth - 1));

   row_type stimulus_table [0:19] = '{
      '{'0, '0, 1'b1, '0},
      '{'0, Max, 1'b1, '0},
      '{Max, '0, 1'b1, '0},
      '{One, '0, 1'b1, '0},
      '{One, One, 1'b1, One},
      '{One, Two, 1'b1, Two},
      '{Two, Two, 1'b1, word_type'(Bias + 2) << MantWidth},
      '{OneHalf, OneHalf, 1'b0, '0},
      '{Max, Max, 1'b0, '0},
      '{Max, One, 1'b1, Max},
      '{word_type'(1), word_type'(1), 1'b1, '0},
      '{word_type'(1) << MantWidth, One, 1'b1, word_type'(1) << MantWidth},
      '{word_type'(1), One, 1'b0, '0},
      '{{ExpWidth'(0), {MantWidth{1'b1}}}, {ExpWidth'(0), {MantWidth{1'b1}}}, 1'b1, '0},
      '{word_type'(Bias - 1) << MantWidth, One, 1'b0, '0},
      '{{ExpWidth'(Bias), {MantWidth{1'b1}}}, {ExpWidth'(Bias), {MantWidth{1'b1}}}, 1'b0, '0},
      '{word_type'(200) << MantWidth, word_type'(200) << MantWidth, 1'b0, '0},
      '{word_type'(20) << MantWidth, word_type'(50) << MantWidth, 1'b0, '0},
      '{word_type'(63) << MantWidth, word_type'(64) << MantWidth, 1'b0, '0},
      '{31'h2AAAAAAA, 31'h55555555, 1'b0, '0}
   };

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      error_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (stimulus_table[i]) begin
         if (stimulus_table[i].known &&
             float_product(stimulus_table[i].a, stimulus_table[i].b) !== stimulus_table[i].want)
            report_mismatch("table", float_product(stimulus_table[i].a, stimulus_table[i].b),
                            stimulus_table[i].want);
         send_word(stimulus_table[i].a, stimulus_table[i].b);
      end
      for (int n = 0; n < 850; n++) begin
         if ($urandom_range(0, 19) == 0)
            send_word($urandom_range(0, 1) ? '0 : random_operand(), random_operand());
         else
            send_word(random_operand(), random_operand());
      end
      req_valid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_products.size() == 0)
         $display("PASS unsigned_float_multiplier");
      else
         $display("FAIL unsigned_float_multiplier");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_products.size() == 0)
               report_mismatch("unexpected", rsp_product, '0);
            else begin
               word_type want;
               want = expected_products.pop_front();
               if (rsp_product !== want)
                  report_mismatch("product", rsp_product, want);
            end
         end
         rsp_ready <= (gap_length() == 0) || ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      #2000000;
      $display("FAIL unsigned_float_multiplier");
      $finish;
   end
endmodule

### filelist.f
+incdir+design
design/ufm_pkg.sv
design/ufm_core.sv
design/unsigned_float_multiplier.sv
tb/unsigned_float_multiplier_tb.sv
